[rtl/core/vpva_pkg.sv]
package vpva_pkg;

  localparam int unsigned BINS   = 1024;
  localparam int unsigned SLOT_W = $clog2(BINS);
  localparam int unsigned SUM_W  = 48;
  localparam int unsigned PROD_W = SUM_W + 7;
  localparam int unsigned WORD_W = SUM_W + 1;

  localparam logic [SLOT_W-1:0] HALF_SLOT = SLOT_W'(BINS / 2);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(BINS - 1);
  localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};

  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_CLADD = 2'd1;

  localparam logic [6:0] PCT_FULL = 7'd100;

  localparam logic REG_BIN_TICKS = 1'b0;
  localparam logic REG_VA_PCT    = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] price;
    logic [31:0] volume;
  } req_t;

  typedef struct packed {
    logic [31:0] poc_bin;
    logic [31:0] val_bin;
    logic [31:0] vah_bin;
    logic [47:0] total_volume;
    logic        area_valid;
    logic [15:0] dropped_ticks;
  } res_t;

  typedef struct packed {
    logic latch;
    logic div_step;
    logic clr;
    logic off;
    logic drop;
    logic rd;
    logic wr;
    logic cl_init;
    logic sl_rd;
    logic sl_chk;
    logic sr_rd;
    logic sr_chk;
    logic sp_hi;
    logic mul;
    logic add;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic clr_last;
    logic active;
    logic kind_close;
    logic kind_tick;
    logic in_range;
    logic poc_zero;
    logic sp_lo_end;
    logic sp_hi_end;
    logic rd_used;
    logic cover_ok;
    logic take_left;
  } sts_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  function automatic logic [31:0] slot_to_bin(input logic [31:0] base,
                                              input logic [SLOT_W-1:0] slot);
    return base + 32'(slot) - 32'(HALF_SLOT);
  endfunction

endpackage

[rtl/core/volume_profile_value_area_core.sv]
// Volume profile with point of control and value area.
// Requests enter on req_i when start is high and busy is low; busy then stays
// high until the request is fully handled, and start is ignored meanwhile.
// A close of an active profile (kind 1, 2 or 3) gives one result on res_o,
// marked by res_valid_o for exactly one cycle; the receiver cannot stall it.
// Tick handling: a 32-step restoring divider (price / bin_ticks), then one
// read-modify-write of the bin store; a tick outside the store's range is
// dropped. The first tick of a profile adds a clearing pass over all 1024
// slots of the store.
// Close: from the point of control the walk reads the bin store slot by slot to
// find the nearest used slot on each side, then per value-area step multiplies,
// compares against the target and adds the larger neighbour (right on a tie).
// Configuration is on the APB port: bin_ticks at 0x0, value_area_pct at 0x4.
// The user must write them only while busy is low; the block does not enforce it.
// Reset returns registers to 1 and 70, leaves no profile active; a profile start clears the store.
module volume_profile_value_area_core import vpva_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  req_t        req_i,
  output res_t        res_o,
  output logic        res_valid_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] bin_ticks_q;
  logic [6:0]  pct_q;
  cmd_t        cmd;
  sts_t        sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_ticks_q <= 16'd1;
      pct_q       <= 7'd70;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_BIN_TICKS) begin
        bin_ticks_q <= pwdata[15:0];
      end else begin
        pct_q <= pwdata[6:0];
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_VA_PCT) ? {25'd0, pct_q} : {16'd0, bin_ticks_q};

  vpva_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .emit_o  (res_valid_o)
  );

  vpva_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .bin_ticks_i (bin_ticks_q),
    .pct_i       (pct_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (res_o)
  );

endmodule

[rtl/core/vpva_ram.sv]
module vpva_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/core/vpva_dp.sv]
module vpva_dp import vpva_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  req_t        req_i,
  input  logic [15:0] bin_ticks_i,
  input  logic [6:0]  pct_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output res_t        res_o
);

  logic [1:0]         kind_q;
  logic [31:0]        vol_q;
  logic [15:0]        rem_q;
  logic [31:0]        quo_q;
  logic [4:0]         dcnt_q;
  logic [SLOT_W-1:0]  clr_q;
  logic               active_q;
  logic [31:0]        base_q;
  logic [SLOT_W-1:0]  poc_q;
  logic [SUM_W-1:0]   pocv_q, sum_q;
  logic [15:0]        drop_q;
  logic [SLOT_W-1:0]  slot_q;
  logic               inr_q;
  logic [SLOT_W-1:0]  sptr_q, lo_q, hi_q, left_q, right_q;
  logic               lnone_q, rnone_q;
  logic [SUM_W-1:0]   lv_q, rv_q, summed_q;
  logic [PROD_W-1:0]  prod_q, p_q;

  logic [15:0]        ticks;
  logic [16:0]        rem_sh;
  logic               ge;
  logic [15:0]        rem_nx;
  logic [33:0]        off;
  logic [6:0]         pct_c;
  logic [SUM_W-1:0]   rd_vol, new_v, vol_ext;
  logic               rd_used;
  logic               we;
  logic [SLOT_W-1:0]  waddr, raddr;
  logic [WORD_W-1:0]  wdata, rdata;
  logic               take_left;

  assign ticks   = (bin_ticks_i == 16'd0) ? 16'd1 : bin_ticks_i;
  assign rem_sh  = {rem_q, quo_q[31]};
  assign ge      = rem_sh >= {1'b0, ticks};
  assign rem_nx  = ge ? 16'(rem_sh - {1'b0, ticks}) : rem_sh[15:0];
  assign off     = {2'b00, quo_q} - {2'b00, base_q} + 34'(HALF_SLOT);
  assign pct_c   = (pct_i > PCT_FULL) ? PCT_FULL : pct_i;
  assign rd_vol  = rdata[SUM_W-1:0];
  assign rd_used = rdata[SUM_W];
  assign vol_ext = SUM_W'(vol_q);
  assign new_v   = sat_add(rd_vol, vol_ext);
  assign take_left = !lnone_q && (rnone_q || (lv_q > rv_q));

  always_comb begin
    we    = 1'b0;
    waddr = slot_q;
    wdata = {1'b1, new_v};
    if (cmd_i.clr) begin
      we    = 1'b1;
      waddr = clr_q;
      wdata = {(clr_q == HALF_SLOT), {SUM_W{1'b0}}};
    end else if (cmd_i.wr) begin
      we = 1'b1;
    end
  end

  always_comb begin
    raddr = slot_q;
    if (cmd_i.sl_rd) begin
      raddr = sptr_q - 1'b1;
    end else if (cmd_i.sr_rd) begin
      raddr = sptr_q + 1'b1;
    end
  end

  vpva_ram #(
    .WIDTH (WORD_W),
    .DEPTH (BINS)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      dcnt_q   <= '0;
      clr_q    <= '0;
      lnone_q  <= 1'b0;
      rnone_q  <= 1'b0;
    end else begin
      if (cmd_i.latch) begin
        kind_q <= req_i.kind;
        vol_q  <= req_i.volume;
        quo_q  <= req_i.price;
        rem_q  <= '0;
        dcnt_q <= '0;
      end
      if (cmd_i.div_step) begin
        rem_q  <= rem_nx;
        quo_q  <= {quo_q[30:0], ge};
        dcnt_q <= dcnt_q + 1'b1;
      end
      if (cmd_i.clr) begin
        clr_q    <= clr_q + 1'b1;
        active_q <= 1'b1;
        base_q   <= quo_q;
        poc_q    <= HALF_SLOT;
        pocv_q   <= '0;
        sum_q    <= '0;
        drop_q   <= '0;
      end
      if (cmd_i.off) begin
        slot_q <= off[SLOT_W-1:0];
        inr_q  <= (off[33:SLOT_W] == '0);
      end
      if (cmd_i.drop && (drop_q != 16'hFFFF)) begin
        drop_q <= drop_q + 1'b1;
      end
      if (cmd_i.wr) begin
        sum_q <= sat_add(sum_q, vol_ext);
        if (new_v > pocv_q) begin
          pocv_q <= new_v;
          poc_q  <= slot_q;
        end
      end
      if (cmd_i.cl_init) begin
        lo_q     <= poc_q;
        hi_q     <= poc_q;
        sptr_q   <= poc_q;
        summed_q <= pocv_q;
        p_q      <= sum_q * pct_c;
      end
      if (cmd_i.sl_rd) begin
        if (sptr_q == '0) begin
          lnone_q <= 1'b1;
        end else begin
          sptr_q <= sptr_q - 1'b1;
        end
      end
      if (cmd_i.sl_chk && rd_used) begin
        left_q  <= sptr_q;
        lv_q    <= rd_vol;
        lnone_q <= 1'b0;
      end
      if (cmd_i.sr_rd) begin
        if (sptr_q == LAST_SLOT) begin
          rnone_q <= 1'b1;
        end else begin
          sptr_q <= sptr_q + 1'b1;
        end
      end
      if (cmd_i.sr_chk && rd_used) begin
        right_q <= sptr_q;
        rv_q    <= rd_vol;
        rnone_q <= 1'b0;
      end
      if (cmd_i.sp_hi) begin
        sptr_q <= hi_q;
      end
      if (cmd_i.mul) begin
        prod_q <= summed_q * PCT_FULL;
      end
      if (cmd_i.add) begin
        if (take_left) begin
          summed_q <= sat_add(summed_q, lv_q);
          lo_q     <= left_q;
          sptr_q   <= left_q;
        end else begin
          summed_q <= sat_add(summed_q, rv_q);
          hi_q     <= right_q;
          sptr_q   <= right_q;
        end
      end
      if (cmd_i.emit) begin
        active_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.div_last   = (dcnt_q == 5'd31);
    sts_o.clr_last   = (clr_q == LAST_SLOT);
    sts_o.active     = active_q;
    sts_o.kind_close = (kind_q != KIND_ADD);
    sts_o.kind_tick  = (kind_q == KIND_ADD) || (kind_q == KIND_CLADD);
    sts_o.in_range   = inr_q;
    sts_o.poc_zero   = (pocv_q == '0);
    sts_o.sp_lo_end  = (sptr_q == '0);
    sts_o.sp_hi_end  = (sptr_q == LAST_SLOT);
    sts_o.rd_used    = rd_used;
    sts_o.cover_ok   = (prod_q >= p_q) || (lnone_q && rnone_q);
    sts_o.take_left  = take_left;
  end

  always_comb begin
    res_o.total_volume  = sum_q;
    res_o.dropped_ticks = drop_q;
    res_o.area_valid    = (pocv_q != '0);
    if (pocv_q == '0) begin
      res_o.poc_bin = '0;
      res_o.val_bin = '0;
      res_o.vah_bin = '0;
    end else begin
      res_o.poc_bin = slot_to_bin(base_q, poc_q);
      res_o.val_bin = slot_to_bin(base_q, lo_q);
      res_o.vah_bin = slot_to_bin(base_q, hi_q);
    end
  end

endmodule

[rtl/core/vpva_ctrl.sv]
module vpva_ctrl import vpva_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o,
  output logic emit_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_CL_INIT = 4'd2;
  localparam logic [3:0] S_SL_RD   = 4'd3;
  localparam logic [3:0] S_SL_CHK  = 4'd4;
  localparam logic [3:0] S_SR_RD   = 4'd5;
  localparam logic [3:0] S_SR_CHK  = 4'd6;
  localparam logic [3:0] S_MUL     = 4'd7;
  localparam logic [3:0] S_CMP     = 4'd8;
  localparam logic [3:0] S_ADD     = 4'd9;
  localparam logic [3:0] S_EMIT    = 4'd10;
  localparam logic [3:0] S_DIV     = 4'd11;
  localparam logic [3:0] S_CLR     = 4'd12;
  localparam logic [3:0] S_OFF     = 4'd13;
  localparam logic [3:0] S_RD      = 4'd14;
  localparam logic [3:0] S_WR      = 4'd15;

  logic [3:0] state_q, state_d;
  logic       first_q, first_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
    end
  end

  always_comb begin
    state_d = state_q;
    first_d = first_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DISP;
        end
      end
      S_DISP: begin
        if (sts_i.kind_close && sts_i.active) begin
          state_d = S_CL_INIT;
        end else if (sts_i.kind_tick) begin
          state_d = S_DIV;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_CL_INIT: begin
        cmd_o.cl_init = 1'b1;
        first_d       = 1'b1;
        state_d       = sts_i.poc_zero ? S_EMIT : S_SL_RD;
      end
      S_SL_RD: begin
        cmd_o.sl_rd = 1'b1;
        if (sts_i.sp_lo_end) begin
          cmd_o.sp_hi = first_q;
          state_d     = first_q ? S_SR_RD : S_MUL;
        end else begin
          state_d = S_SL_CHK;
        end
      end
      S_SL_CHK: begin
        cmd_o.sl_chk = 1'b1;
        if (sts_i.rd_used) begin
          cmd_o.sp_hi = first_q;
          state_d     = first_q ? S_SR_RD : S_MUL;
        end else begin
          state_d = S_SL_RD;
        end
      end
      S_SR_RD: begin
        cmd_o.sr_rd = 1'b1;
        first_d     = 1'b0;
        state_d     = sts_i.sp_hi_end ? S_MUL : S_SR_CHK;
      end
      S_SR_CHK: begin
        cmd_o.sr_chk = 1'b1;
        state_d      = sts_i.rd_used ? S_MUL : S_SR_RD;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_CMP;
      end
      S_CMP: begin
        state_d = sts_i.cover_ok ? S_EMIT : S_ADD;
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = sts_i.take_left ? S_SL_RD : S_SR_RD;
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        state_d    = sts_i.kind_tick ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = sts_i.active ? S_OFF : S_CLR;
        end
      end
      S_CLR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_OFF;
        end
      end
      S_OFF: begin
        cmd_o.off = 1'b1;
        state_d   = S_RD;
      end
      S_RD: begin
        if (sts_i.in_range) begin
          cmd_o.rd = 1'b1;
          state_d  = S_WR;
        end else begin
          cmd_o.drop = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_WR: begin
        cmd_o.wr = 1'b1;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign emit_o = cmd_o.emit;

endmodule

[rtl/core/vpva_chk.sv]
module vpva_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic res_valid_o,
  input logic pready
);

  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy) else $error("result outside busy window");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted request not busy");

  a_res_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o) else $error("result strobe too long");

  a_idle_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && pready) |=> !res_valid_o || busy)
    else $error("result without request");

endmodule

bind volume_profile_value_area_core vpva_chk u_vpva_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .pready      (pready)
);
